// ===== design/asd_pkg.sv =====
// ----------------------------------------------------------------------------
// asd_pkg
// Shared types and constants of the accelerometer stillness detector.
// ----------------------------------------------------------------------------
package asd_pkg;

   localparam int NUM_AXES    = 3;
   localparam int QUEUE_DEPTH = 2;
   localparam int DIV_STEPS   = 32;
   localparam int STILL_GAIN  = 800;
   localparam int DIFF_GAIN   = 1000;

   typedef enum logic [2:0] {
      REG_STEP_THRESHOLD = 3'd0,
      REG_MEAN_THRESHOLD = 3'd1,
      REG_AXES_NEEDED    = 3'd2,
      REG_HOLD_WINDOWS   = 3'd3,
      REG_WINDOW_LIMIT   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [15:0] step_threshold;
      logic [15:0] mean_threshold;
      logic [1:0]  axes_needed;
      logic [7:0]  hold_windows;
      logic [9:0]  window_limit;
   } cfg_type;

   // one classified sample on its way from front to back
   typedef struct packed {
      logic                      ignored;
      logic                      close;
      logic [15:0]               g;
      logic [NUM_AXES-1:0][15:0] adiff;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_START,
      BK_DIV,
      BK_CHECK,
      BK_MUL_A,
      BK_MUL_B,
      BK_CMP,
      BK_UPDATE
   } back_state_type;

endpackage

// ===== design/asd_front.sv =====
// ----------------------------------------------------------------------------
// asd_front
// Accepts samples, forms per-axis absolute differences and classifies each
// transaction (ignored, accumulate, window end with effective length).
// ----------------------------------------------------------------------------
module asd_front import asd_pkg::*; #(
   parameter int AXIS_DIVISOR = 3
) (
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [15:0]      req_accel_x,
   input  logic [15:0]      req_accel_y,
   input  logic [15:0]      req_accel_z,
   input  logic [15:0]      req_sample_index,
   input  logic [15:0]      req_window_len,
   input  queue_status_type q_status,
   output logic             q_push,
   output item_type         q_data
);

   // reciprocal of the divisor, exact for every 10-bit operand
   localparam int RECIP_SHIFT = 11;
   localparam int RECIP       = ((1 << RECIP_SHIFT) + AXIS_DIVISOR - 1) / AXIS_DIVISOR;

   logic [NUM_AXES-1:0][15:0] prev_ff, prev_in;
   logic [NUM_AXES-1:0][15:0] cur;
   logic [16:0]               diff [NUM_AXES];
   logic                      ignored;
   logic [21:0]               len_scaled;
   logic [21:0]               lim_scaled;

   assign cur        = {req_accel_z, req_accel_y, req_accel_x};
   assign req_ready  = !q_status.full;
   assign q_push     = req_valid && req_ready;
   assign ignored    = req_sample_index > {6'd0, cfg.window_limit};
   assign len_scaled = {12'd0, req_window_len[9:0]} * 22'(RECIP);
   assign lim_scaled = {12'd0, cfg.window_limit} * 22'(RECIP);

   always_comb begin
      q_data.ignored = ignored;
      q_data.close   = (req_window_len != 16'd0) &&
                       (req_sample_index == req_window_len - 16'd1);
      if (req_window_len < {6'd0, cfg.window_limit}) begin
         q_data.g = {5'd0, len_scaled[21:11]};
      end else begin
         q_data.g = {5'd0, lim_scaled[21:11]} - 16'd1;
      end
      prev_in = prev_ff;
      for (int k = 0; k < NUM_AXES; k++) begin
         diff[k]        = {cur[k][15], cur[k]} - {prev_ff[k][15], prev_ff[k]};
         q_data.adiff[k] = diff[k][16] ? 16'(-diff[k]) : diff[k][15:0];
      end
      if (q_push && !ignored) begin
         prev_in = cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
      end else begin
         prev_ff <= prev_in;
      end
   end

endmodule

// ===== design/asd_queue.sv =====
// ----------------------------------------------------------------------------
// asd_queue
// Short FIFO between front and back so that each side stalls on its own.
// ----------------------------------------------------------------------------
module asd_queue import asd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  item_type         push_data,
   input  logic             pop,
   output item_type         pop_data,
   output queue_status_type status
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   item_type               mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]       wr_ff, wr_in, rd_ff, rd_in;
   logic [PTR_W:0]         cnt_ff, cnt_in;

   assign status.full  = cnt_ff == (PTR_W+1)'(QUEUE_DEPTH);
   assign status.empty = cnt_ff == '0;
   assign pop_data     = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== design/asd_back.sv =====
// ----------------------------------------------------------------------------
// asd_back
// Accumulates window sums, judges each axis at window end through a shared
// serial divider and multiplier, and holds the result register.
// ----------------------------------------------------------------------------
module asd_back import asd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  queue_status_type q_status,
   input  item_type         q_data,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_is_still,
   output logic             rsp_window_closed,
   output logic             rsp_sample_ignored
);

   back_state_type      state_ff, state_in;
   item_type            item_ff, item_in;
   logic [31:0]         sum_ff [NUM_AXES];
   logic [31:0]         sum_in [NUM_AXES];
   logic [31:0]         large_ff [NUM_AXES];
   logic [31:0]         large_in [NUM_AXES];
   logic [15:0]         small_ff [NUM_AXES];
   logic [15:0]         small_in [NUM_AXES];
   logic [1:0]          k_ff, k_in;
   logic [1:0]          n_ff, n_in;
   logic [15:0]         rem_ff, rem_in;
   logic [31:0]         quot_ff, quot_in;
   logic [4:0]          cnt_ff, cnt_in;
   logic [15:0]         d_ff, d_in;
   logic [47:0]         p1_ff, p1_in;
   logic signed [27:0]  t_ff, t_in;
   logic signed [44:0]  p2_ff, p2_in;
   logic [7:0]          still_ff, still_in;
   logic [7:0]          moving_ff, moving_in;
   logic                flag_ff, flag_in;
   logic                closed_ff, closed_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_still_ff, rsp_still_in;
   logic                rsp_closed_ff, rsp_closed_in;
   logic                rsp_ignored_ff, rsp_ignored_in;
   logic                done_ff, done_in;
   logic [16:0]         rem_shift;
   logic                qbit;
   logic                axis_done, axis_still;
   logic [15:0]         s_cur;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_is_still       = rsp_still_ff;
   assign rsp_window_closed  = rsp_closed_ff;
   assign rsp_sample_ignored = rsp_ignored_ff;

   assign s_cur     = small_ff[k_ff];
   assign rem_shift = {rem_ff, quot_ff[31]};
   assign qbit      = rem_shift >= {1'b0, item_ff.g};

   always_comb begin
      state_in       = state_ff;
      item_in        = item_ff;
      sum_in         = sum_ff;
      large_in       = large_ff;
      small_in       = small_ff;
      k_in           = k_ff;
      n_in           = n_ff;
      rem_in         = rem_ff;
      quot_in        = quot_ff;
      cnt_in         = cnt_ff;
      d_in           = d_ff;
      p1_in          = p1_ff;
      t_in           = t_ff;
      p2_in          = p2_ff;
      still_in       = still_ff;
      moving_in      = moving_ff;
      flag_in        = flag_ff;
      closed_in      = closed_ff;
      done_in        = 1'b0;
      q_pop          = 1'b0;
      axis_done      = 1'b0;
      axis_still     = 1'b0;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_still_in   = rsp_still_ff;
      rsp_closed_in  = rsp_closed_ff;
      rsp_ignored_in = rsp_ignored_ff;

      case (state_ff)
         BK_IDLE: begin
            // a finished item waits here until the result register is free
            if (done_ff) begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_in   = 1'b1;
                  rsp_still_in   = flag_ff;
                  rsp_closed_in  = closed_ff;
                  rsp_ignored_in = item_ff.ignored;
               end else begin
                  done_in = 1'b1;
               end
            end else if (!q_status.empty) begin
               q_pop     = 1'b1;
               item_in   = q_data;
               closed_in = 1'b0;
               done_in   = 1'b1;
               if (!q_data.ignored) begin
                  for (int k = 0; k < NUM_AXES; k++) begin
                     if (q_data.adiff[k] <= cfg.step_threshold) begin
                        small_in[k] = small_ff[k] + 16'd1;
                     end else begin
                        large_in[k] = large_ff[k] + {16'd0, q_data.adiff[k]};
                     end
                     sum_in[k] = sum_ff[k] + {16'd0, q_data.adiff[k]};
                  end
                  if (q_data.close) begin
                     if (q_data.g == 16'd0) begin
                        for (int k = 0; k < NUM_AXES; k++) begin
                           sum_in[k]   = '0;
                           large_in[k] = '0;
                           small_in[k] = '0;
                        end
                     end else begin
                        done_in  = 1'b0;
                        k_in     = '0;
                        n_in     = '0;
                        state_in = BK_START;
                     end
                  end
               end
            end
         end
         BK_START: begin
            rem_in   = '0;
            quot_in  = sum_ff[k_ff];
            cnt_in   = '0;
            state_in = BK_DIV;
         end
         BK_DIV: begin
            rem_in  = qbit ? 16'(rem_shift - {1'b0, item_ff.g}) : rem_shift[15:0];
            quot_in = {quot_ff[30:0], qbit};
            cnt_in  = cnt_ff + 5'd1;
            if (cnt_ff == 5'(DIV_STEPS-1)) begin
               state_in = BK_CHECK;
            end
         end
         BK_CHECK: begin
            d_in = item_ff.g - s_cur;
            if (quot_ff <= {16'd0, cfg.mean_threshold}) begin
               axis_done  = 1'b1;
               axis_still = 1'b1;
            end else if ({s_cur, 1'b0} <= {1'b0, item_ff.g}) begin
               axis_done = 1'b1;
            end else if (s_cur > item_ff.g) begin
               axis_done  = 1'b1;
               axis_still = 1'b1;
            end else if (s_cur == item_ff.g) begin
               axis_done = 1'b1;
            end else begin
               state_in = BK_MUL_A;
            end
         end
         BK_MUL_A: begin
            p1_in    = large_ff[k_ff] * s_cur;
            t_in     = 28'(signed'({12'd0, s_cur}) * STILL_GAIN) -
                       28'(signed'({12'd0, d_ff}) * DIFF_GAIN);
            state_in = BK_MUL_B;
         end
         BK_MUL_B: begin
            p2_in    = 45'(signed'({1'b0, d_ff}) * t_ff);
            state_in = BK_CMP;
         end
         BK_CMP: begin
            axis_done  = 1'b1;
            axis_still = signed'({1'b0, p1_ff}) <= 49'(p2_ff);
         end
         BK_UPDATE: begin
            if (n_ff >= cfg.axes_needed) begin
               still_in  = (still_ff == 8'hFF) ? still_ff : still_ff + 8'd1;
               moving_in = '0;
            end else begin
               still_in  = '0;
               moving_in = (moving_ff == 8'hFF) ? moving_ff : moving_ff + 8'd1;
            end
            if (still_in >= cfg.hold_windows) begin
               flag_in = 1'b1;
            end else if (moving_in >= cfg.hold_windows) begin
               flag_in = 1'b0;
            end
            for (int k = 0; k < NUM_AXES; k++) begin
               sum_in[k]   = '0;
               large_in[k] = '0;
               small_in[k] = '0;
            end
            closed_in = 1'b1;
            done_in   = 1'b1;
            state_in  = BK_IDLE;
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase

      // advance to the next axis or to the window verdict
      if (axis_done) begin
         n_in = n_ff + {1'b0, axis_still};
         if (k_ff == 2'(NUM_AXES-1)) begin
            state_in = BK_UPDATE;
         end else begin
            k_in     = k_ff + 2'd1;
            state_in = BK_START;
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff        <= item_in;
      k_ff           <= k_in;
      n_ff           <= n_in;
      rem_ff         <= rem_in;
      quot_ff        <= quot_in;
      cnt_ff         <= cnt_in;
      d_ff           <= d_in;
      p1_ff          <= p1_in;
      t_ff           <= t_in;
      p2_ff          <= p2_in;
      closed_ff      <= closed_in;
      rsp_still_ff   <= rsp_still_in;
      rsp_closed_ff  <= rsp_closed_in;
      rsp_ignored_ff <= rsp_ignored_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         still_ff     <= '0;
         moving_ff    <= '0;
         flag_ff      <= 1'b0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < NUM_AXES; k++) begin
            sum_ff[k]   <= '0;
            large_ff[k] <= '0;
            small_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         still_ff     <= still_in;
         moving_ff    <= moving_in;
         flag_ff      <= flag_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
         sum_ff       <= sum_in;
         large_ff     <= large_in;
         small_ff     <= small_in;
      end
   end

endmodule

// ===== design/accel_stillness_detector.sv =====
// ----------------------------------------------------------------------------
// accel_stillness_detector
// Three-axis stillness detector with per-window judgment and hysteresis flag.
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  req      req_valid/req_ready   accel x/y/z, sample_index, window_len
//  rsp      rsp_valid/rsp_ready   is_still, window_closed, sample_ignored
//  csr      csr_valid/csr_ready   csr_index, csr_wdata (always ready)
//
//  An ordinary sample passes the queue, the back end's item register and the
//  result register before rsp_valid rises; a sample that closes a window also
//  waits on the back end's 32-step serial divider and multiply steps per axis.
//  Reset is synchronous and clears the sums, counters and flag at once.
//  A two-entry queue lets samples enter while the back end works or the
//  result register waits for rsp_ready.
// ----------------------------------------------------------------------------
module accel_stillness_detector import asd_pkg::*; #(
   parameter int AXIS_DIVISOR = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_accel_x,
   input  logic [15:0] req_accel_y,
   input  logic [15:0] req_accel_z,
   input  logic [15:0] req_sample_index,
   input  logic [15:0] req_window_len,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_is_still,
   output logic        rsp_window_closed,
   output logic        rsp_sample_ignored,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   cfg_type          cfg_ff, cfg_in;
   queue_status_type q_status;
   item_type         push_data, pop_data;
   logic             q_push, q_pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_STEP_THRESHOLD: cfg_in.step_threshold = csr_wdata;
            REG_MEAN_THRESHOLD: cfg_in.mean_threshold = csr_wdata;
            REG_AXES_NEEDED:    cfg_in.axes_needed    = csr_wdata[1:0];
            REG_HOLD_WINDOWS:   cfg_in.hold_windows   = csr_wdata[7:0];
            REG_WINDOW_LIMIT:   cfg_in.window_limit   = csr_wdata[9:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_threshold <= 16'd100;
         cfg_ff.mean_threshold <= 16'd50;
         cfg_ff.axes_needed    <= 2'd2;
         cfg_ff.hold_windows   <= 8'd3;
         cfg_ff.window_limit   <= 10'd200;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   asd_front #(.AXIS_DIVISOR(AXIS_DIVISOR)) u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_accel_x      (req_accel_x),
      .req_accel_y      (req_accel_y),
      .req_accel_z      (req_accel_z),
      .req_sample_index (req_sample_index),
      .req_window_len   (req_window_len),
      .q_status         (q_status),
      .q_push           (q_push),
      .q_data           (push_data)
   );

   asd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   asd_back u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .q_status           (q_status),
      .q_data             (pop_data),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_is_still       (rsp_is_still),
      .rsp_window_closed  (rsp_window_closed),
      .rsp_sample_ignored (rsp_sample_ignored)
   );

`ifndef NO_ASSERTIONS
   a_closed_not_ignored: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_window_closed && rsp_sample_ignored))
      else $error("result both closed a window and was ignored");

   a_full_blocks_req: assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> !req_ready)
      else $error("request taken while queue full");

   a_queue_status: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue both full and empty");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("queue popped while empty");
`endif

endmodule

// ===== sim/asd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asd_checker
// Watches the sample, result and register channels of the stillness detector,
// keeps its own copy of the window sums, counters and motion flag, and
// compares every result transaction with the predicted one.
// ----------------------------------------------------------------------------
module asd_checker import asd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [15:0] req_accel_x,
   input  logic [15:0] req_accel_y,
   input  logic [15:0] req_accel_z,
   input  logic [15:0] req_sample_index,
   input  logic [15:0] req_window_len,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_is_still,
   input  logic        rsp_window_closed,
   input  logic        rsp_sample_ignored,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int          failures,
   output int          outstanding
);

   localparam int DIVISOR = 3;

   typedef struct {
      bit still;
      bit closed;
      bit ignored;
   } verdict_type;

   cfg_type     cfg;
   logic [15:0] last_sample [NUM_AXES];
   logic [31:0] diff_total  [NUM_AXES];
   logic [31:0] large_total [NUM_AXES];
   logic [15:0] small_count [NUM_AXES];
   logic [7:0]  still_run;
   logic [7:0]  moving_run;
   bit          flag;
   verdict_type verdicts [$];

   function automatic bit axis_is_still(int k, logic [15:0] g);
      longint s, d, l;
      if (diff_total[k] / g <= cfg.mean_threshold) return 1'b1;
      s = small_count[k];
      if (2 * s <= longint'(g)) return 1'b0;
      d = longint'(g) - s;
      if (d < 0) return 1'b1;
      if (d == 0) return 1'b0;
      l = large_total[k];
      return l * s <= d * (STILL_GAIN * s - DIFF_GAIN * d);
   endfunction

   task automatic classify_sample(input logic [15:0] acc [NUM_AXES],
                                  input logic [15:0] idx, input logic [15:0] len,
                                  output verdict_type v);
      logic [15:0] g;
      int          dif;
      logic [31:0] mag;
      int          n;
      v = '{flag, 1'b0, 1'b0};
      if (len < cfg.window_limit) g = 16'(len / DIVISOR);
      else g = 16'(cfg.window_limit / DIVISOR) - 16'd1;
      if (idx > cfg.window_limit) begin
         v.ignored = 1'b1;
         return;
      end
      for (int k = 0; k < NUM_AXES; k++) begin
         dif = int'($signed(acc[k])) - int'($signed(last_sample[k]));
         mag = (dif < 0) ? -dif : dif;
         if (mag <= cfg.step_threshold) small_count[k] = small_count[k] + 16'd1;
         else large_total[k] = large_total[k] + mag;
         diff_total[k]  = diff_total[k] + mag;
         last_sample[k] = acc[k];
      end
      if (len != 0 && idx == len - 16'd1) begin
         if (g != 0) begin
            n = 0;
            for (int k = 0; k < NUM_AXES; k++) n += axis_is_still(k, g);
            if (n >= cfg.axes_needed) begin
               if (still_run != 8'hff) still_run++;
               moving_run = 0;
            end else begin
               still_run = 0;
               if (moving_run != 8'hff) moving_run++;
            end
            if (still_run >= cfg.hold_windows) flag = 1'b1;
            else if (moving_run >= cfg.hold_windows) flag = 1'b0;
            v.closed = 1'b1;
         end
         for (int k = 0; k < NUM_AXES; k++) begin
            diff_total[k]  = 0;
            large_total[k] = 0;
            small_count[k] = 0;
         end
      end
      v.still = flag;
   endtask

   always @(posedge clock) begin
      verdict_type v;
      logic [15:0] acc [NUM_AXES];
      int          errs;
      errs = 0;
      if (reset) begin
         cfg = '{16'd100, 16'd50, 2'd2, 8'd3, 10'd200};
         for (int k = 0; k < NUM_AXES; k++) begin
            last_sample[k] = 0;
            diff_total[k]  = 0;
            large_total[k] = 0;
            small_count[k] = 0;
         end
         still_run  = 0;
         moving_run = 0;
         flag       = 1'b0;
         verdicts.delete();
         failures <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               REG_STEP_THRESHOLD: cfg.step_threshold = csr_wdata;
               REG_MEAN_THRESHOLD: cfg.mean_threshold = csr_wdata;
               REG_AXES_NEEDED:    cfg.axes_needed    = csr_wdata[1:0];
               REG_HOLD_WINDOWS:   cfg.hold_windows   = csr_wdata[7:0];
               REG_WINDOW_LIMIT:   cfg.window_limit   = csr_wdata[9:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            acc = '{req_accel_x, req_accel_y, req_accel_z};
            classify_sample(acc, req_sample_index, req_window_len, v);
            verdicts.push_back(v);
         end
         if (rsp_valid && rsp_ready) begin
            if (verdicts.size() == 0) begin
               $error("result transaction with no sample outstanding");
               errs++;
            end else begin
               v = verdicts.pop_front();
               if (rsp_is_still !== v.still) begin
                  $error("is_still: expected %0d, got %0d", v.still, rsp_is_still);
                  errs++;
               end
               if (rsp_window_closed !== v.closed) begin
                  $error("window_closed: expected %0d, got %0d", v.closed,
                         rsp_window_closed);
                  errs++;
               end
               if (rsp_sample_ignored !== v.ignored) begin
                  $error("sample_ignored: expected %0d, got %0d", v.ignored,
                         rsp_sample_ignored);
                  errs++;
               end
            end
         end
         failures <= failures + errs;
      end
      outstanding <= verdicts.size();
   end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives accelerometer windows, stray samples and register settings into the
// stillness detector with random gaps and result stalls; the checker beside
// the block predicts each result and counts mismatches for the verdict.
// ----------------------------------------------------------------------------
module tb;
   import asd_pkg::*;

   localparam int STALL_LIMIT = 5000;

   logic        clock;
   logic        reset;
   logic        req_valid, req_ready;
   logic [15:0] req_accel_x, req_accel_y, req_accel_z;
   logic [15:0] req_sample_index, req_window_len;
   logic        rsp_valid, rsp_ready;
   logic        rsp_is_still, rsp_window_closed, rsp_sample_ignored;
   logic        csr_valid, csr_ready;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;
   int          failures, outstanding;
   int          max_gap;
   int          quiet_cycles;
   logic [9:0]  limit_now;

   accel_stillness_detector dut (.*);

   asd_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // result side: draw a stall for every transaction
   initial begin
      int stall;
      stall = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) stall = $urandom_range(max_gap, 0);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // drop valid and wait until every expected result has come
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_reg(csr_index_type idx, logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == REG_WINDOW_LIMIT) limit_now = data[9:0];
   endtask

   task automatic configure(logic [15:0] step, logic [15:0] mean, logic [1:0] axes,
                            logic [7:0] hold, logic [9:0] lim);
      drain();
      write_reg(REG_STEP_THRESHOLD, step);
      write_reg(REG_MEAN_THRESHOLD, mean);
      write_reg(REG_AXES_NEEDED, 16'(axes));
      write_reg(REG_HOLD_WINDOWS, 16'(hold));
      write_reg(REG_WINDOW_LIMIT, 16'(lim));
      csr_valid <= 1'b0;
   endtask

   task automatic send_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                              logic [15:0] idx, logic [15:0] len);
      int gap;
      req_valid        <= 1'b1;
      req_accel_x      <= x;
      req_accel_y      <= y;
      req_accel_z      <= z;
      req_sample_index <= idx;
      req_window_len   <= len;
      do @(posedge clock); while (!req_ready);
      gap = $urandom_range(max_gap, 0);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic [15:0] jitter(logic [15:0] base, int amp);
      int n;
      n = $urandom_range(amp, 0);
      return $urandom_range(1, 0) ? base + 16'(n) : base - 16'(n);
   endfunction

   // one well-formed window with random content around a resting level
   task automatic send_window(output int count);
      logic [15:0] level [3];
      int          len, top, amp;
      top = (limit_now + 1 < 40) ? limit_now + 1 : 40;
      if (top < 1) top = 1;
      len = ($urandom_range(9, 0) == 0) ? $urandom_range(limit_now + 8, 0)
                                        : $urandom_range(top, 1);
      case ($urandom_range(3, 0))
         0: amp = 20;
         1: amp = 200;
         2: amp = 3000;
         default: amp = 65535;
      endcase
      for (int k = 0; k < 3; k++) level[k] = 16'($urandom);
      for (int i = 0; i < len; i++)
         send_sample(jitter(level[0], amp), jitter(level[1], amp),
                     jitter(level[2], amp), 16'(i), 16'(len));
      count = len;
   endtask

   task automatic random_phase(int quota, bit hold_off);
      int sent;
      int cnt;
      sent = 0;
      while (sent < quota) begin
         if ($urandom_range(9, 0) == 0) begin
            send_sample(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                        $urandom_range(1, 0) ? 16'($urandom) : 16'd0);
            sent++;
         end else begin
            send_window(cnt);
            sent += cnt;
         end
         if (hold_off && sent > quota / 2) begin
            drain();
            hold_off = 1'b0;
         end
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_accel_x = '0;
      req_accel_y = '0;
      req_accel_z = '0;
      req_sample_index = '0;
      req_window_len = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      max_gap    = 0;
      limit_now  = 10'd200;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, stray index, zero length, zero effective length
      send_sample(16'h7fff, 16'h8000, 16'h0000, 16'd0, 16'd6);
      send_sample(16'h8000, 16'h7fff, 16'hffff, 16'd1, 16'd6);
      send_sample(16'h0001, 16'h0001, 16'h0001, 16'd65535, 16'd6);
      send_sample(16'h0001, 16'h0002, 16'h0003, 16'd201, 16'd6);
      for (int i = 2; i < 6; i++) send_sample(16'd5, 16'd5, 16'd5, 16'(i), 16'd6);
      send_sample(16'd5, 16'd5, 16'd5, 16'd3, 16'd0);
      send_sample(16'd5, 16'd5, 16'd5, 16'd0, 16'd1);
      send_sample(16'd5, 16'd5, 16'd5, 16'd0, 16'd2);
      send_sample(16'd5, 16'd5, 16'd5, 16'd199, 16'd65535);
      for (int w = 0; w < 3; w++)
         for (int i = 0; i < 3; i++)
            send_sample(16'd7, 16'd7, 16'd7, 16'(i), 16'd3);
      configure(16'd0, 16'd0, 2'd3, 8'd1, 10'd3);
      send_sample(16'd1, 16'd2, 16'd3, 16'd2, 16'd3);
      send_sample(16'd1, 16'd2, 16'd3, 16'd3, 16'd300);
      send_sample(16'd1, 16'd2, 16'd3, 16'd4, 16'd5);

      max_gap = 16;
      configure(16'd100, 16'd50, 2'd2, 8'd3, 10'd200);
      random_phase(160, 1'b1);
      max_gap = 0;
      configure(16'd0, 16'd0, 2'd3, 8'd1, 10'd1023);
      random_phase(150, 1'b0);
      max_gap = 16;
      configure(16'hffff, 16'hffff, 2'd0, 8'd255, 10'd3);
      random_phase(120, 1'b0);
      configure(16'd300, 16'd100, 2'd1, 8'd0, 10'd40);
      random_phase(150, 1'b0);
      max_gap = 4;
      configure(16'd2000, 16'd500, 2'd2, 8'd2, 10'd60);
      random_phase(150, 1'b0);
      max_gap = 16;
      configure(16'($urandom), 16'($urandom), 2'($urandom), 8'($urandom),
                10'($urandom_range(1023, 3)));
      random_phase(150, 1'b0);
      configure(16'($urandom), 16'($urandom), 2'($urandom), 8'($urandom),
                10'($urandom));
      random_phase(150, 1'b0);
      configure(16'd150, 16'd80, 2'd2, 8'd1, 10'd30);
      random_phase(160, 1'b0);

      drain();
      repeat (200) @(posedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
